/* design/bnms_pkg.sv */
// ----------------------------------------------------------------------------
// bnms_pkg
// Types, sizes and codes shared by the non-maximum suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;

	localparam int MAX_KEPT  = 256;
	localparam int KIDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W     = $clog2(MAX_KEPT + 1);

	localparam int COORD_W   = 16;
	localparam int LABEL_W   = 8;
	localparam int EDGE_W    = COORD_W + 2;
	localparam int AREA_W    = 2 * COORD_W;
	localparam int UNION_W   = AREA_W + 1;
	localparam int THR_W     = 16;
	localparam int PROD_W    = UNION_W + THR_W;
	localparam int IDX_W     = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC = 1'd1;

	localparam logic [THR_W-1:0] THR_RESET = 16'd29491;
	localparam logic [IDX_W-1:0] IDX_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
		logic [LABEL_W-1:0] label;
	} box_t;

	localparam int ENTRY_W = $bits(box_t);

	typedef struct packed {
		logic hit_valid;
		logic hit;
		logic busy;
	} iou_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

/* design/box_non_max_suppression.sv */
// ----------------------------------------------------------------------------
// box_non_max_suppression
// Greedy non-maximum suppression over score-sorted boxes with a kept store
// in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  box_left .. first_of_frame
//  out       output     out_valid / out_stall keep, proposal_index, store_overflow
//  cfg       input      cfg_write            cfg_index, cfg_data
//
//  A box is accepted, the kept store is read back one entry per cycle through
//  the RAM read port, the compare pipeline drains and the result is posted;
//  with an empty store the scan and drain are skipped. The kept-store scan
//  sets the rate at which boxes pass.
//  Reset clears kept count and box counter, presets configuration; RAM needs none.
//  A result waits in the output register; a new box is taken meanwhile, and
//  its result is held back while out_stall stays high.
// ----------------------------------------------------------------------------
module box_non_max_suppression import bnms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_W-1:0]    box_left,
	input  logic [COORD_W-1:0]    box_top,
	input  logic [COORD_W-1:0]    box_width,
	input  logic [COORD_W-1:0]    box_height,
	input  logic [LABEL_W-1:0]    class_label,
	input  logic                  first_of_frame,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  keep,
	output logic [IDX_W-1:0]      proposal_index,
	output logic                  store_overflow,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t             state_q, state_d;
	box_t               box_q, rd_entry;
	logic [CNT_W-1:0]   kept_cnt_q, scan_cnt_q, rd_ptr_q, eff_cnt;
	logic [IDX_W-1:0]   box_cnt_q, idx_q, eff_idx;
	logic [THR_W-1:0]   thr_q;
	logic               agn_q;
	logic               rd_v_q, sup_q;
	logic               accept, rd_en, out_free, load_out, wr_en, full;
	iou_stat_t          stat;

	assign accept   = in_valid && !in_stall;
	assign eff_cnt  = first_of_frame ? '0 : kept_cnt_q;
	assign eff_idx  = first_of_frame ? '0 : box_cnt_q;
	assign out_free = !out_valid || !out_stall;
	assign full     = (kept_cnt_q == CNT_W'(MAX_KEPT));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (eff_cnt != '0) ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (rd_ptr_q == scan_cnt_q - CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_v_q && !stat.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SCAN:   rd_en    = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: load_out = out_free;
			default:   ;
		endcase
	end

	assign wr_en = load_out && !sup_q && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kept_cnt_q <= '0;
			box_cnt_q  <= '0;
			rd_v_q     <= 1'b0;
			sup_q      <= 1'b0;
			out_valid  <= 1'b0;
			thr_q      <= THR_RESET;
			agn_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_q  <= rd_en;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_IOU_THRESHOLD:  thr_q <= cfg_data[THR_W-1:0];
					REG_CLASS_AGNOSTIC: agn_q <= cfg_data[0];
					default:            ;
				endcase
			end
			if (accept) begin
				kept_cnt_q <= eff_cnt;
				box_cnt_q  <= (eff_idx == IDX_MAX) ? IDX_MAX : eff_idx + IDX_W'(1);
				sup_q      <= 1'b0;
			end else if (stat.hit_valid && stat.hit) begin
				sup_q <= 1'b1;
			end
			if (wr_en) begin
				kept_cnt_q <= kept_cnt_q + CNT_W'(1);
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			box_q.left   <= box_left;
			box_q.top    <= box_top;
			box_q.width  <= box_width;
			box_q.height <= box_height;
			box_q.label  <= class_label;
			scan_cnt_q   <= eff_cnt;
			rd_ptr_q     <= '0;
			idx_q        <= eff_idx;
		end else if (rd_en) begin
			rd_ptr_q <= rd_ptr_q + CNT_W'(1);
		end
		if (load_out) begin
			keep           <= !sup_q;
			proposal_index <= idx_q;
			store_overflow <= !sup_q && full;
		end
	end

	bnms_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_KEPT)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (kept_cnt_q[KIDX_W-1:0]),
		.wdata (box_q),
		.re    (rd_en),
		.raddr (rd_ptr_q[KIDX_W-1:0]),
		.rdata (rd_entry)
	);

	bnms_iou u_iou (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (rd_v_q),
		.entry       (rd_entry),
		.box         (box_q),
		.thr         (thr_q),
		.agnostic    (agn_q),
		.stat        (stat)
	);

endmodule

/* design/bnms_ram.sv */
// ----------------------------------------------------------------------------
// bnms_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/bnms_iou.sv */
// ----------------------------------------------------------------------------
// bnms_iou
// Pipelined overlap test of the current box against one kept entry a cycle:
// overlap, areas, union, scaled threshold, compare.
// ----------------------------------------------------------------------------
module bnms_iou import bnms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             entry_valid,
	input  box_t             entry,
	input  box_t             box,
	input  logic [THR_W-1:0] thr,
	input  logic             agnostic,
	output iou_stat_t        stat
);

	logic signed [EDGE_W-1:0] al, ar, bl, br, lo_x, hi_x;
	logic signed [EDGE_W-1:0] at, ab, bt, bb, lo_y, hi_y;
	logic [COORD_W-1:0]       ovx, ovy;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                match_s1, match_s2, match_s3, match_s4;
	logic [COORD_W-1:0]  ovx_s1, ovy_s1, bw_s1, bh_s1;
	logic [AREA_W-1:0]   inter_s2, barea_s2, inter_s3, inter_s4;
	logic [UNION_W-1:0]  uni_s3;
	logic [PROD_W-1:0]   prod_s4;
	logic [AREA_W-1:0]   area_q;

	always_comb begin
		al = EDGE_W'($signed(box.left));
		ar = al + $signed({2'b00, box.width});
		bl = EDGE_W'($signed(entry.left));
		br = bl + $signed({2'b00, entry.width});
		lo_x = (al > bl) ? al : bl;
		hi_x = (ar < br) ? ar : br;
		ovx = (hi_x > lo_x) ? COORD_W'(hi_x - lo_x) : '0;

		at = EDGE_W'($signed(box.top));
		ab = at + $signed({2'b00, box.height});
		bt = EDGE_W'($signed(entry.top));
		bb = bt + $signed({2'b00, entry.height});
		lo_y = (at > bt) ? at : bt;
		hi_y = (ab < bb) ? ab : bb;
		ovy = (hi_y > lo_y) ? COORD_W'(hi_y - lo_y) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= entry_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		area_q   <= box.width * box.height;

		match_s1 <= agnostic || (entry.label == box.label);
		ovx_s1   <= ovx;
		ovy_s1   <= ovy;
		bw_s1    <= entry.width;
		bh_s1    <= entry.height;

		match_s2 <= match_s1;
		inter_s2 <= ovx_s1 * ovy_s1;
		barea_s2 <= bw_s1 * bh_s1;

		match_s3 <= match_s2;
		inter_s3 <= inter_s2;
		uni_s3   <= {1'b0, area_q} + {1'b0, barea_s2} - {1'b0, inter_s2};

		match_s4 <= match_s3;
		inter_s4 <= inter_s3;
		prod_s4  <= thr * uni_s3;
	end

	always_comb begin
		stat.hit_valid = v_s4;
		stat.hit       = match_s4 && ({1'b0, inter_s4, 16'h0000} > prod_s4);
		stat.busy      = v_s1 | v_s2 | v_s3 | v_s4;
	end

endmodule

/* design/bnms_checker.sv */
// ----------------------------------------------------------------------------
// bnms_checker
// Port-level checks of the suppression block, bound to the top level.
// ----------------------------------------------------------------------------
module bnms_checker import bnms_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  keep,
	input logic [IDX_W-1:0]      proposal_index,
	input logic                  store_overflow
);

	// one transaction in flight: stall right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepted transaction");

	// a new result only appears while the input side is busy
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result posted without a transaction in progress");

	a_overflow_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_overflow |-> keep)
		else $error("overflow reported on a suppressed box");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(keep)
			&& $stable(proposal_index) && $stable(store_overflow))
		else $error("stalled result changed");

endmodule

bind box_non_max_suppression bnms_checker u_bnms_checker (.*);
